// File: rtl/core/epli_pkg.sv
package epli_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W = 2 * DIFF_W;
   localparam int HALF_W = SQ_W / 2;
   localparam int PROD_W = 2 * SQ_W;
   localparam int WIDE_W = PROD_W + 34;
   localparam int INT_W = 16;
   localparam int PATH_W = 26;
   localparam int RAD_W = 64;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SREM_W = ROOT_W + 4;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int NUM_REGS = 6;
   localparam int ITER_STAGES = INT_W;
   localparam int NUM_STAGES = 5 + ITER_STAGES + 1;

   localparam logic [2:0] REG_EMITTER_X = 3'd0;
   localparam logic [2:0] REG_EMITTER_Y = 3'd1;
   localparam logic [2:0] REG_EMITTER_Z = 3'd2;
   localparam logic [2:0] REG_RECEIVER_X = 3'd3;
   localparam logic [2:0] REG_RECEIVER_Y = 3'd4;
   localparam logic [2:0] REG_RECEIVER_Z = 3'd5;

   localparam logic [PATH_W-1:0] PATH_MAX = '1;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic last;
      logic zero;
      logic [PROD_W-1:0] ab;
      logic [WIDE_W-1:0] rem;
      logic [WIDE_W-1:0] y;
      logic [INT_W-1:0] q;
      sqrt_type sa;
      sqrt_type sb;
   } iter_type;

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_step(sqrt_type s);
      sqrt_type o;
      logic [SREM_W-1:0] r;
      logic [SREM_W-1:0] t;
      r = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
      t = {2'b00, s.root, 2'b01};
      o.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (r >= t) begin
         o.rem = r - t;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem = r;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

// File: rtl/core/echo_path_length_and_incidence_core.sv
// channel   dir  handshake              payload
// req       in   req_valid / req_stall  req_point_x/y/z, req_last_point
// rsp       out  rsp_valid / rsp_stall  rsp_intensity, rsp_path_length, rsp_last_result
// csr       in   apb write/read         six 24-bit origin registers
//
// 22 register stages: diff, products, sums, partial products, wide sums, then
// 16 stages of one cosine bit and two square-root digits each, then the output.
// one request enters per cycle while the output is not held.
// reset clears the valid bits and the origin registers.
// rsp_stall freezes every stage at once while rsp_valid is high; req_stall is raised while it does.
module echo_path_length_and_incidence_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [epli_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [epli_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [epli_pkg::COORD_W-1:0] req_point_z,
   input  logic req_last_point,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [epli_pkg::INT_W-1:0] rsp_intensity,
   output logic [epli_pkg::PATH_W-1:0] rsp_path_length,
   output logic rsp_last_result,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [epli_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [epli_pkg::DATA_W-1:0] csr_pwdata,
   output logic [epli_pkg::DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import epli_pkg::*;

   logic signed [COORD_W-1:0] cfg_ff [NUM_REGS];
   logic [2:0] csr_idx;
   logic adv;
   logic [NUM_STAGES-1:0] vld_ff;

   // stage 1
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [DIFF_W-1:0] v_ff [3];
   logic last1_ff;
   // stage 2
   logic signed [SQ_W-1:0] sqd_ff [3];
   logic signed [SQ_W-1:0] sqv_ff [3];
   logic signed [SQ_W-1:0] dv_ff [3];
   logic last2_ff;
   // stage 3
   logic [SQ_W-1:0] a3_ff, b3_ff, dm3_ff;
   logic zero3_ff, last3_ff;
   logic [SQ_W+1:0] a_sum, b_sum;
   logic signed [SQ_W+1:0] dot_sum;
   logic dot_pos;
   // stage 4
   logic [SQ_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff, dll_ff, dlh_ff, dhh_ff;
   logic [SQ_W-1:0] a4_ff, b4_ff;
   logic zero4_ff, last4_ff;
   // stage 5 and the iteration chain
   iter_type it_ff [ITER_STAGES+1];
   iter_type it_in [ITER_STAGES];
   iter_type it0_in;
   logic [PROD_W-1:0] ab5, dd5;
   // output
   logic [INT_W-1:0] int_ff;
   logic [PATH_W-1:0] path_ff;
   logic last_ff;
   logic [ROOT_W:0] path_sum;

   assign csr_idx = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cfg_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_idx)
            REG_EMITTER_X: cfg_ff[0] <= csr_pwdata[COORD_W-1:0];
            REG_EMITTER_Y: cfg_ff[1] <= csr_pwdata[COORD_W-1:0];
            REG_EMITTER_Z: cfg_ff[2] <= csr_pwdata[COORD_W-1:0];
            REG_RECEIVER_X: cfg_ff[3] <= csr_pwdata[COORD_W-1:0];
            REG_RECEIVER_Y: cfg_ff[4] <= csr_pwdata[COORD_W-1:0];
            REG_RECEIVER_Z: cfg_ff[5] <= csr_pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_EMITTER_X: csr_prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff[0]};
         REG_EMITTER_Y: csr_prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff[1]};
         REG_EMITTER_Z: csr_prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff[2]};
         REG_RECEIVER_X: csr_prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff[3]};
         REG_RECEIVER_Y: csr_prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff[4]};
         REG_RECEIVER_Z: csr_prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_ff[5]};
         default: csr_prdata = '0;
      endcase
   end

   // whole pipe moves together unless the output is held
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= DIFF_W'(req_point_x) - DIFF_W'(cfg_ff[0]);
         d_ff[1] <= DIFF_W'(req_point_y) - DIFF_W'(cfg_ff[1]);
         d_ff[2] <= DIFF_W'(req_point_z) - DIFF_W'(cfg_ff[2]);
         v_ff[0] <= DIFF_W'(req_point_x) - DIFF_W'(cfg_ff[3]);
         v_ff[1] <= DIFF_W'(req_point_y) - DIFF_W'(cfg_ff[4]);
         v_ff[2] <= DIFF_W'(req_point_z) - DIFF_W'(cfg_ff[5]);
         last1_ff <= req_last_point;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sqd_ff[i] <= SQ_W'(d_ff[i] * d_ff[i]);
            sqv_ff[i] <= SQ_W'(v_ff[i] * v_ff[i]);
            dv_ff[i] <= SQ_W'(d_ff[i] * v_ff[i]);
         end
         last2_ff <= last1_ff;
      end
   end

   always_comb begin
      a_sum = (SQ_W+2)'(unsigned'(sqd_ff[0])) + (SQ_W+2)'(unsigned'(sqd_ff[1]))
            + (SQ_W+2)'(unsigned'(sqd_ff[2]));
      b_sum = (SQ_W+2)'(unsigned'(sqv_ff[0])) + (SQ_W+2)'(unsigned'(sqv_ff[1]))
            + (SQ_W+2)'(unsigned'(sqv_ff[2]));
      dot_sum = (SQ_W+2)'(dv_ff[0]) + (SQ_W+2)'(dv_ff[1]) + (SQ_W+2)'(dv_ff[2]);
      dot_pos = !dot_sum[SQ_W+1] && (dot_sum != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a3_ff <= a_sum[SQ_W-1:0];
         b3_ff <= b_sum[SQ_W-1:0];
         dm3_ff <= dot_pos ? dot_sum[SQ_W-1:0] : '0;
         zero3_ff <= (a_sum == '0) || (b_sum == '0) || !dot_pos;
         last3_ff <= last2_ff;
      end
   end

   // split the 50-bit operands into 25-bit halves
   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff <= SQ_W'(a3_ff[HALF_W-1:0] * b3_ff[HALF_W-1:0]);
         lh_ff <= SQ_W'(a3_ff[HALF_W-1:0] * b3_ff[SQ_W-1:HALF_W]);
         hl_ff <= SQ_W'(a3_ff[SQ_W-1:HALF_W] * b3_ff[HALF_W-1:0]);
         hh_ff <= SQ_W'(a3_ff[SQ_W-1:HALF_W] * b3_ff[SQ_W-1:HALF_W]);
         dll_ff <= SQ_W'(dm3_ff[HALF_W-1:0] * dm3_ff[HALF_W-1:0]);
         dlh_ff <= SQ_W'(dm3_ff[HALF_W-1:0] * dm3_ff[SQ_W-1:HALF_W]);
         dhh_ff <= SQ_W'(dm3_ff[SQ_W-1:HALF_W] * dm3_ff[SQ_W-1:HALF_W]);
         a4_ff <= a3_ff;
         b4_ff <= b3_ff;
         zero4_ff <= zero3_ff;
         last4_ff <= last3_ff;
      end
   end

   always_comb begin
      ab5 = (PROD_W'(hh_ff) << SQ_W) + ((PROD_W'(lh_ff) + PROD_W'(hl_ff)) << HALF_W)
          + PROD_W'(ll_ff);
      dd5 = (PROD_W'(dhh_ff) << SQ_W) + (PROD_W'(dlh_ff) << (HALF_W + 1))
          + PROD_W'(dll_ff);
      it0_in.last = last4_ff;
      it0_in.zero = zero4_ff;
      it0_in.ab = ab5;
      // remainder starts at dot^2 * 2^32
      it0_in.rem = {2'b00, dd5, 32'd0};
      it0_in.y = '0;
      it0_in.q = '0;
      it0_in.sa.rad = {2'b00, a4_ff, 12'd0};
      it0_in.sa.rem = '0;
      it0_in.sa.root = '0;
      it0_in.sb.rad = {2'b00, b4_ff, 12'd0};
      it0_in.sb.rem = '0;
      it0_in.sb.root = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff[0] <= it0_in;
      end
   end

   // stage j settles cosine bit K: keep it if (q + 2^K)^2 * ab <= dot^2 * 2^32
   for (genvar j = 0; j < ITER_STAGES; j++) begin : g_iter
      localparam int K = ITER_STAGES - 1 - j;
      logic [WIDE_W-1:0] trial;
      always_comb begin
         trial = (it_ff[j].y << (K + 1)) + ((WIDE_W'(it_ff[j].ab)) << (2 * K));
         it_in[j] = it_ff[j];
         if (trial <= it_ff[j].rem) begin
            it_in[j].rem = it_ff[j].rem - trial;
            it_in[j].y = it_ff[j].y + ((WIDE_W'(it_ff[j].ab)) << K);
            it_in[j].q[K] = 1'b1;
         end
         it_in[j].sa = sqrt_step(sqrt_step(it_ff[j].sa));
         it_in[j].sb = sqrt_step(sqrt_step(it_ff[j].sb));
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            it_ff[j+1] <= it_in[j];
         end
      end
   end

   assign path_sum = (ROOT_W+1)'(it_ff[ITER_STAGES].sa.root)
                   + (ROOT_W+1)'(it_ff[ITER_STAGES].sb.root) + (ROOT_W+1)'(32);

   always_ff @(posedge clock) begin
      if (adv) begin
         int_ff <= it_ff[ITER_STAGES].zero ? '0 : it_ff[ITER_STAGES].q;
         path_ff <= (path_sum[ROOT_W:6] > (ROOT_W-5)'(PATH_MAX)) ? PATH_MAX
                                                               : path_sum[6 +: PATH_W];
         last_ff <= it_ff[ITER_STAGES].last;
      end
   end

   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_intensity = int_ff;
   assign rsp_path_length = path_ff;
   assign rsp_last_result = last_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request did not enter the pipe");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipe moved while output held");

   a_zero_path: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_intensity != '0) |-> (rsp_path_length != '0))
      else $error("nonzero intensity with zero path length");

endmodule
